/* hdl/pes_pkg.sv */
package pes_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    // position of the last hex digit within a three-byte escape
    localparam logic [1:0] DIGIT_LAST   = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PLAIN,
        KIND_ESC
    } t_kind;

    // one queued request: an optional leading escape, then the byte itself
    typedef struct packed {
        logic       pre_esc;
        logic [7:0] pre_byte;
        t_kind      main_kind;
        logic [7:0] main_byte;
        logic       last;
    } t_desc;

    function automatic logic is_reserved(input logic [7:0] b);
        logic r;
        case (b)
            8'h20, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2B, 8'h2C, 8'h2F,
            8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5B,
            8'h5C, 8'h5D, 8'h5E, 8'h7B, 8'h7D, 8'h7C: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_upper(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = 8'h30 + {4'h0, d};
        end else begin
            r = 8'h37 + {4'h0, d};
        end
        return r;
    endfunction

endpackage

/* hdl/pes_front.sv */
module pes_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_in_byte,
    input  logic           i_in_last,
    output logic           o_wr_en,
    output pes_pkg::t_desc o_desc
);

    logic r_pending;
    logic n_pending;
    logic is_nl;

    always_comb begin
        is_nl            = r_pending && (i_in_byte == pes_pkg::CH_LOWER_N);
        o_desc.pre_esc   = r_pending;
        o_desc.pre_byte  = is_nl ? pes_pkg::CH_NEWLINE : pes_pkg::CH_BACKSLASH;
        o_desc.main_byte = i_in_byte;
        o_desc.last      = i_in_last;
        n_pending        = 1'b0;
        if (is_nl) begin
            o_desc.main_kind = pes_pkg::KIND_NONE;
        end else if (i_in_byte == pes_pkg::CH_BACKSLASH && !i_in_last) begin
            // hold until the next byte shows whether it is a newline escape
            o_desc.main_kind = pes_pkg::KIND_NONE;
            n_pending        = 1'b1;
        end else if (pes_pkg::is_reserved(i_in_byte)) begin
            o_desc.main_kind = pes_pkg::KIND_ESC;
        end else begin
            o_desc.main_kind = pes_pkg::KIND_PLAIN;
        end
        // drop requests that produce no output
        o_wr_en = i_accept && (r_pending || o_desc.main_kind != pes_pkg::KIND_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (i_accept) begin
            r_pending <= n_pending;
        end
    end

endmodule

/* hdl/pes_fifo.sv */
module pes_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  pes_pkg::t_desc i_wr_data,
    input  logic           i_rd_en,
    output pes_pkg::t_desc o_rd_data,
    output logic           o_full,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_MAX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    pes_pkg::t_desc r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           wr_do;
    logic           rd_do;

    assign o_full    = (r_count == CNT_MAX);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_do     = i_wr_en && !o_full;
    assign rd_do     = i_rd_en && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_do) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_do) begin
                r_wr_ptr <= (r_wr_ptr == PTR_MAX) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd_do) begin
                r_rd_ptr <= (r_rd_ptr == PTR_MAX) ? '0 : r_rd_ptr + AW'(1);
            end
            if (wr_do && !rd_do) begin
                r_count <= r_count + CW'(1);
            end else if (rd_do && !wr_do) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* hdl/pes_back.sv */
module pes_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  pes_pkg::t_desc i_head,
    output logic           o_head_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic           o_message_end
);

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_run_last;
    logic       r_out_msg_end;
    logic       r_pre_done;
    logic [1:0] r_digit;

    logic       on_pre;
    logic       unit_esc;
    logic [7:0] unit_byte;
    logic [7:0] cur_byte;
    logic       unit_end;
    logic       item_end;
    logic       advance;

    always_comb begin
        on_pre    = i_head.pre_esc && !r_pre_done;
        unit_esc  = on_pre || (i_head.main_kind == pes_pkg::KIND_ESC);
        unit_byte = on_pre ? i_head.pre_byte : i_head.main_byte;
        case (r_digit)
            2'd0:    cur_byte = unit_esc ? pes_pkg::CH_PERCENT : unit_byte;
            2'd1:    cur_byte = pes_pkg::hex_upper(unit_byte[7:4]);
            default: cur_byte = pes_pkg::hex_upper(unit_byte[3:0]);
        endcase
        unit_end = !unit_esc || (r_digit == pes_pkg::DIGIT_LAST);
        item_end = unit_end && (!on_pre || i_head.main_kind == pes_pkg::KIND_NONE);
        // advance whenever the output register is free or being drained
        advance  = i_head_valid && (!r_out_valid || pop);
    end

    assign o_head_pop    = advance && item_end;
    assign empty         = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_out_run_last;
    assign o_message_end = r_out_msg_end;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte     <= cur_byte;
            r_out_run_last <= item_end;
            r_out_msg_end  <= item_end && i_head.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pre_done  <= 1'b0;
            r_digit     <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                if (item_end) begin
                    r_pre_done <= 1'b0;
                    r_digit    <= '0;
                end else if (unit_end) begin
                    r_pre_done <= 1'b1;
                    r_digit    <= '0;
                end else begin
                    r_digit <= r_digit + 2'd1;
                end
            end
        end
    end

endmodule

/* hdl/percent_encoder_stream.sv */
// Streaming percent encoder.
// Input side is a queue: drive i_in_byte/i_in_last with push; a request is
// taken on a clock edge with push high and full low. i_in_last marks the
// final byte of a message.
// Output side is a queue: while empty is low, o_out_byte, o_run_last and
// o_message_end show the oldest result; pop high takes it at the edge.
// Reserved characters leave as three bytes ('%' and two upper-case hex
// digits), all others as one byte; backslash then 'n' leaves as %0A.
// A backslash that is not last is held and leaves with the next request.
// With nothing queued ahead, the first result of a request passes through
// the queue memory and then the output register before it shows.
// Throughput: while the queue holds a request and the receiver pops, the
// back end emits one byte per cycle; a request leaves as one byte (plain)
// to three bytes (escape), up to six when a held backslash is flushed ahead.
// A DEPTH-entry queue sits between classification and expansion; when the
// receiver stalls the output register holds its byte, the queue fills and
// full rises. Synchronous reset empties the queue and the output register
// and clears any held backslash.
module percent_encoder_stream #(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_message_end
);

    logic           accept;
    logic           wr_en;
    pes_pkg::t_desc wr_desc;
    pes_pkg::t_desc head;
    logic           q_empty;
    logic           head_pop;

    assign accept = push && !full;

    pes_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_wr_en   (wr_en),
        .o_desc    (wr_desc)
    );

    pes_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_data (wr_desc),
        .i_rd_en   (head_pop),
        .o_rd_data (head),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    pes_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (!q_empty),
        .i_head        (head),
        .o_head_pop    (head_pop),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

endmodule

/* hdl/pes_checker.sv */
module pes_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_message_end
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("output not empty after reset");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_message_end) |-> o_run_last)
        else $error("message end without run end");

    a_percent_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_byte == pes_pkg::CH_PERCENT) |-> !o_run_last)
        else $error("percent sign ends a run");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_run_last)))
        else $error("stalled result changed");

endmodule

bind percent_encoder_stream pes_checker u_pes_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_out_byte    (o_out_byte),
    .o_run_last    (o_run_last),
    .o_message_end (o_message_end)
);
